[rtl/core/smf_pkg.sv]
`timescale 1ns / 1ps

package smf_pkg;

  // Number of window snapshots the queue between front and back can hold.
  localparam int QUEUE_DEPTH = 2;

  // Queue status as seen by the front (space left) and the back (data waiting).
  typedef struct packed {
    logic not_empty;
    logic not_full;
  } q_stat_t;

endpackage

[rtl/core/smf_if.sv]
`timescale 1ns / 1ps

// Channel that carries one converter sample per word.
interface smf_sample_if #(
  parameter int SAMPLE_BITS = 16
) ();
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

// Channel that carries one filtered median per word.
interface smf_median_if #(
  parameter int SAMPLE_BITS = 16
) ();
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] median;

  modport source (output valid, output median, input ready);
  modport sink (input valid, input median, output ready);
endinterface

[rtl/core/smf_front.sv]
`timescale 1ns / 1ps

module smf_front
  import smf_pkg::*;
#(
  parameter int WINDOW_LEN  = 5,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  smf_sample_if.sink                        sample_ch,
  input  q_stat_t                           q_stat,
  output logic                              push,
  output logic [WINDOW_LEN*SAMPLE_BITS-1:0] push_data
);

  // The median does not depend on the order of the entries, so the circular
  // window is kept as a shift line with the newest sample at tap zero.
  logic [SAMPLE_BITS-1:0] window      [WINDOW_LEN];
  logic [SAMPLE_BITS-1:0] window_next [WINDOW_LEN];

  assign sample_ch.ready = q_stat.not_full;
  assign push            = sample_ch.valid && q_stat.not_full;

  always_comb begin
    window_next[0] = sample_ch.sample;
    for (int k = 1; k < WINDOW_LEN; k++) begin
      window_next[k] = window[k-1];
    end
    for (int k = 0; k < WINDOW_LEN; k++) begin
      push_data[k*SAMPLE_BITS +: SAMPLE_BITS] = window_next[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < WINDOW_LEN; k++) begin
        window[k] <= '0;
      end
    end else if (push) begin
      for (int k = 0; k < WINDOW_LEN; k++) begin
        window[k] <= window_next[k];
      end
    end
  end

endmodule

[rtl/core/smf_queue.sv]
`timescale 1ns / 1ps

module smf_queue
  import smf_pkg::*;
#(
  parameter int WIDTH = 80
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output q_stat_t          q_stat
);

  localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
  localparam int CNT_BITS = PTR_BITS + 1;

  logic [WIDTH-1:0]    entries [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] count;

  assign q_stat.not_empty = (count != '0);
  assign q_stat.not_full  = (count != CNT_BITS'(QUEUE_DEPTH));
  assign pop_data         = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // The depth is a power of two, so the pointers wrap on their own.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_BITS'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_BITS'(1);
      end else if (pop && !push) begin
        count <= count - CNT_BITS'(1);
      end
    end
  end

endmodule

[rtl/core/smf_back.sv]
`timescale 1ns / 1ps

module smf_back
  import smf_pkg::*;
#(
  parameter int WINDOW_LEN  = 5,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  q_stat_t                           q_stat,
  input  logic [WINDOW_LEN*SAMPLE_BITS-1:0] pop_data,
  output logic                              pop,
  smf_median_if.source                      median_ch
);

  localparam int MID_INDEX = (WINDOW_LEN - 1) / 2;
  localparam int RANK_BITS = $clog2(WINDOW_LEN);

  logic [SAMPLE_BITS-1:0] win      [WINDOW_LEN];
  logic [RANK_BITS-1:0]   rank     [WINDOW_LEN];
  logic [WINDOW_LEN-1:0]  sel;
  logic                   advance;

  logic                   s1_valid;
  logic [SAMPLE_BITS-1:0] s1_win [WINDOW_LEN];
  logic [WINDOW_LEN-1:0]  s1_sel;
  logic [SAMPLE_BITS-1:0] picked;

  // The whole back pipeline moves together whenever the output register is free.
  assign advance = !median_ch.valid || median_ch.ready;
  assign pop     = advance && q_stat.not_empty;

  // Each entry's rank is the count of entries that sort before it; ties are
  // broken by tap position so that the ranks form a permutation.
  always_comb begin
    for (int i = 0; i < WINDOW_LEN; i++) begin
      win[i]  = pop_data[i*SAMPLE_BITS +: SAMPLE_BITS];
    end
    for (int i = 0; i < WINDOW_LEN; i++) begin
      rank[i] = '0;
      for (int j = 0; j < WINDOW_LEN; j++) begin
        if (j != i) begin
          if ((win[j] < win[i]) || ((win[j] == win[i]) && (j < i))) begin
            rank[i] = rank[i] + RANK_BITS'(1);
          end
        end
      end
      sel[i] = (rank[i] == RANK_BITS'(MID_INDEX));
    end
  end

  // Exactly one select bit is set, so an OR of the masked entries picks it.
  always_comb begin
    picked = '0;
    for (int i = 0; i < WINDOW_LEN; i++) begin
      picked = picked | (s1_win[i] & {SAMPLE_BITS{s1_sel[i]}});
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_sel           <= sel;
      median_ch.median <= picked;
      for (int i = 0; i < WINDOW_LEN; i++) begin
        s1_win[i] <= win[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid        <= 1'b0;
      median_ch.valid <= 1'b0;
    end else if (advance) begin
      s1_valid        <= q_stat.not_empty;
      median_ch.valid <= s1_valid;
    end
  end

endmodule

[rtl/core/sliding_median_filter.sv]
`timescale 1ns / 1ps

// Channel      Direction  Word     Fields
// sample_ch    in         sample   sample[SAMPLE_BITS-1:0], unsigned reading
// median_ch    out        median   median[SAMPLE_BITS-1:0], median of window
//
// One sample word is taken every cycle while the queue has room; the comparison
// matrix in the rank stage of the back end sets that rate. A median passes the
// queue, the rank stage and the output register. Reset (rst, synchronous) zeroes the
// window, empties the queue and drops median_ch.valid; the first medians therefore
// count the zero entries. When median_ch stalls, the back end holds and the two-word
// queue keeps taking samples until it fills, after which sample_ch.ready drops.

module sliding_median_filter
  import smf_pkg::*;
#(
  parameter int WINDOW_LEN  = 5,
  parameter int SAMPLE_BITS = 16
) (
  input  logic         clk,
  input  logic         rst,
  smf_sample_if.sink   sample_ch,
  smf_median_if.source median_ch
);

  localparam int SNAP_BITS = WINDOW_LEN * SAMPLE_BITS;

  // Status of the snapshot queue, shared by both ends.
  q_stat_t                q_stat;
  logic                   push;
  logic                   pop;
  logic [SNAP_BITS-1:0]   push_data;
  logic [SNAP_BITS-1:0]   pop_data;

  // The front end updates the window and queues a snapshot of it for each
  // accepted sample.
  smf_front #(
    .WINDOW_LEN  (WINDOW_LEN),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .sample_ch (sample_ch),
    .q_stat    (q_stat),
    .push      (push),
    .push_data (push_data)
  );

  // The queue lets the front keep accepting while the output is stalled.
  smf_queue #(
    .WIDTH (SNAP_BITS)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .q_stat    (q_stat)
  );

  // The back end ranks the snapshot entries and registers the middle one.
  smf_back #(
    .WINDOW_LEN  (WINDOW_LEN),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_stat    (q_stat),
    .pop_data  (pop_data),
    .pop       (pop),
    .median_ch (median_ch)
  );

endmodule

[rtl/core/smf_checker.sv]
`timescale 1ns / 1ps

module smf_checker #(
  parameter int SAMPLE_BITS = 16
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [SAMPLE_BITS-1:0] out_median
);

  // Queue, rank stage and output register hold at most four words.
  localparam int MAX_IN_FLIGHT = 4;

  logic       in_acc;
  logic       out_acc;
  logic [2:0] in_flight;
  logic       first_word;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_flight  <= '0;
      first_word <= 1'b1;
    end else begin
      if (in_acc && !out_acc) begin
        in_flight <= in_flight + 3'd1;
      end else if (out_acc && !in_acc) begin
        in_flight <= in_flight - 3'd1;
      end
      if (out_acc) begin
        first_word <= 1'b0;
      end
    end
  end

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("median word dropped while stalled");

  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_flight != 3'd0)
    else $error("median word shown with no sample outstanding");

  a_bound: assert property (@(posedge clk) disable iff (rst)
    in_flight <= 3'(MAX_IN_FLIGHT))
    else $error("more samples in flight than the pipeline holds");

  a_reset_clears: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("median valid after reset");

  a_first_zero: assert property (@(posedge clk) disable iff (rst)
    out_acc && first_word |-> out_median == '0)
    else $error("first median after reset is not zero");

endmodule

bind sliding_median_filter smf_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_smf_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (sample_ch.valid),
  .in_ready   (sample_ch.ready),
  .out_valid  (median_ch.valid),
  .out_ready  (median_ch.ready),
  .out_median (median_ch.median)
);

[tb/sv/smf_median_checker.sv]
`timescale 1ns / 1ps

// Watches both channels of the median filter. It keeps its own copy of the
// five-entry window, works out the median for every accepted sample word, and
// compares each accepted median word with the oldest prediction.
module smf_median_checker #(
  parameter int WINDOW_LEN  = 5,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   sample_valid,
  input  logic                   sample_ready,
  input  logic [SAMPLE_BITS-1:0] sample,
  input  logic                   median_valid,
  input  logic                   median_ready,
  input  logic [SAMPLE_BITS-1:0] median,
  output int                     error_count,
  output int                     pending_medians,
  output int                     checked_medians
);

  localparam int MID_RANK = (WINDOW_LEN - 1) / 2;

  logic [SAMPLE_BITS-1:0] window_q [WINDOW_LEN];
  int                     next_slot;
  logic [SAMPLE_BITS-1:0] expected_medians [$];

  // Ranks every entry, breaking ties by position, and returns the one whose
  // rank is the middle rank.
  function automatic logic [SAMPLE_BITS-1:0] window_median();
    int rank;
    for (int i = 0; i < WINDOW_LEN; i++) begin
      rank = 0;
      for (int j = 0; j < WINDOW_LEN; j++) begin
        if (window_q[j] < window_q[i] || (window_q[j] == window_q[i] && j < i)) begin
          rank++;
        end
      end
      if (rank == MID_RANK) begin
        return window_q[i];
      end
    end
    return '0;
  endfunction

  always @(posedge clk) begin : track
    logic [SAMPLE_BITS-1:0] want;
    if (rst) begin
      for (int i = 0; i < WINDOW_LEN; i++) begin
        window_q[i] = '0;
      end
      next_slot = 0;
      expected_medians.delete();
      error_count = 0;
      checked_medians = 0;
    end else begin
      if (sample_valid && sample_ready) begin
        window_q[next_slot] = sample;
        next_slot = (next_slot + 1) % WINDOW_LEN;
        expected_medians.push_back(window_median());
      end
      if (median_valid && median_ready) begin
        if (expected_medians.size() == 0) begin
          $error("median: expected no word, got %0d", median);
          error_count++;
        end else begin
          want = expected_medians.pop_front();
          checked_medians++;
          if (median !== want) begin
            $error("median: expected %0d, got %0d", want, median);
            error_count++;
          end
        end
      end
    end
    pending_medians = expected_medians.size();
  end

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps

// Top of the median filter testbench. It makes the clock, the single reset,
// the sample stream and the back pressure on the median channel. All
// prediction and comparison lives in the checker instantiated beside the block.
module tb;

  localparam int SAMPLE_BITS   = 16;
  localparam int WINDOW_LEN    = 5;
  localparam int RANDOM_WORDS  = 450;
  // The last stretch of the random stream runs with no idling on either side.
  localparam int CALM_WORDS    = 60;
  localparam int DRAIN_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 10;

  logic clk;
  logic rst;
  logic quiet;
  int   sent_words;
  int   directed_words;
  int   error_count;
  int   pending_medians;
  int   checked_medians;

  smf_sample_if #(.SAMPLE_BITS(SAMPLE_BITS)) sample_ch ();
  smf_median_if #(.SAMPLE_BITS(SAMPLE_BITS)) median_ch ();

  sliding_median_filter #(
    .WINDOW_LEN (WINDOW_LEN),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .sample_ch(sample_ch),
    .median_ch(median_ch)
  );

  smf_median_checker #(
    .WINDOW_LEN (WINDOW_LEN),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_median_check (
    .clk            (clk),
    .rst            (rst),
    .sample_valid   (sample_ch.valid),
    .sample_ready   (sample_ch.ready),
    .sample         (sample_ch.sample),
    .median_valid   (median_ch.valid),
    .median_ready   (median_ch.ready),
    .median         (median_ch.median),
    .error_count    (error_count),
    .pending_medians(pending_medians),
    .checked_medians(checked_medians)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop in case the handshake hangs. The slowest legal run needs well
  // under a tenth of this.
  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

  // Back pressure on the median channel. Stalls come in bursts at random points;
  // between bursts ready stays high for a while, and once the calm tail starts it
  // stays high for good. During reset ready is held low.
  initial begin
    median_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && !quiet && $urandom_range(0, 6) == 0) begin
        median_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end
      median_ch.ready <= !rst;
    end
  end

  // Offers one sample word and returns at the edge where it is taken. A random
  // gap may come first, so that idle cycles land before any phase of the
  // filter's work. Ready is sampled at the falling edge, where it is settled
  // for the coming rising edge, so the outcome never depends on the order of
  // processes at the edge itself. Valid gets at most one update per edge.
  task automatic send_word(input logic [SAMPLE_BITS-1:0] value);
    bit taken;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      sample_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    sample_ch.valid  <= 1'b1;
    sample_ch.sample <= value;
    do begin
      @(negedge clk);
      taken = sample_ch.ready;
      @(posedge clk);
    end while (!taken);
    sent_words++;
  endtask

  // Directed words. The window still holds zeros from reset, so the first
  // medians stay at zero until three large samples are in. After that come the
  // field extremes, alternating bit patterns, a run of equal values, and
  // strictly falling and rising runs that move the median through the window.
  task automatic send_directed_words();
    logic [SAMPLE_BITS-1:0] plan [22];
    plan = '{16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000,
             16'h0001, 16'hFFFE, 16'h8000, 16'h7FFF, 16'h5555,
             16'hAAAA, 16'h00FF, 16'hFF00, 16'd1234, 16'd1234,
             16'd1234, 16'd500,  16'd400,  16'd300,  16'd200,
             16'd900,  16'd1000};
    foreach (plan[i]) begin
      send_word(plan[i]);
    end
    directed_words = sent_words;
  endtask

  // Random stream in four flavors, picked word by word: fully random readings,
  // a slowly drifting level (the normal converter case), that level with
  // impulse spikes to either rail (the case a median filter is for), and
  // values from a tiny set so that ties inside the window are common.
  task automatic send_random_words();
    logic [SAMPLE_BITS-1:0] level;
    logic [SAMPLE_BITS-1:0] value;
    level = SAMPLE_BITS'($urandom_range(0, 65535));
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n == RANDOM_WORDS - CALM_WORDS) begin
        quiet <= 1'b1;
      end
      level = level + SAMPLE_BITS'($urandom_range(0, 64)) - SAMPLE_BITS'(32);
      case ($urandom_range(0, 3))
        0: value = SAMPLE_BITS'($urandom_range(0, 65535));
        1: value = level;
        2: begin
          if ($urandom_range(0, 3) == 0) begin
            value = $urandom_range(0, 1) ? '1 : '0;
          end else begin
            value = level;
          end
        end
        default: begin
          value = SAMPLE_BITS'($urandom_range(0, 3));
          if ($urandom_range(0, 1) == 1) begin
            value = ~value;
          end
        end
      endcase
      send_word(value);
    end
  endtask

  initial begin
    int drain;
    rst              <= 1'b1;
    quiet            <= 1'b0;
    sample_ch.valid  <= 1'b0;
    sample_ch.sample <= '0;
    sent_words       = 0;
    directed_words   = 0;
    drain            = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    send_directed_words();
    send_random_words();
    sample_ch.valid <= 1'b0;

    // Let the last medians come out. Every expected word must arrive within
    // the drain limit; anything left over counts as a hang.
    while (pending_medians != 0 && drain < DRAIN_LIMIT) begin
      @(negedge clk);
      drain++;
    end
    if (pending_medians != 0) begin
      $display("status: fail");
      $finish;
    end else begin
      // A few more cycles so that a stray extra median would still be seen.
      repeat (SETTLE_CYCLES) @(posedge clk);
      $display("Sent %0d sample words (%0d directed, the rest random with stalls).",
               sent_words, directed_words);
      $display("Compared %0d median words, %0d mismatches.", checked_medians, error_count);
      if (error_count == 0) begin
        $display("status: pass");
      end else begin
        $display("status: fail");
      end
      $finish;
    end
  end

endmodule
